// ===== hdl/frp_pkg.sv =====
// Package for the frame receive / patch / resend core.
// Holds the phase type, frame marker bytes, register indexes and reset values.
// No dependencies.
package frp_pkg;

  // Frame parser phase
  typedef enum logic [1:0] {
    PH_HUNT    = 2'd0,
    PH_WAIT    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_TRAIL   = 2'd3
  } phase_t;

  // Frame marker bytes
  localparam logic [7:0] HEADER_BYTE = 8'h54;
  localparam logic [7:0] SECOND_BYTE = 8'h00;

  // Configuration register indexes
  localparam logic [1:0] REG_PATCH_ENABLE = 2'd0;
  localparam logic [1:0] REG_PATCH_OFFSET = 2'd1;
  localparam logic [1:0] REG_PATCH_VALUE  = 2'd2;

  // Configuration reset values
  localparam logic       PATCH_ENABLE_RST = 1'b1;
  localparam logic [6:0] PATCH_OFFSET_RST = 7'd17;
  localparam logic [7:0] PATCH_VALUE_RST  = 8'h08;

endpackage

// ===== hdl/frame_receive_patch_resend_core.sv =====
// Top level of the frame receive / patch / resend core.
// Parses 0x54 0x00 framed bytes, patches one byte, resends a recomputed sum.
// Depends on frp_pkg.
//
//   channel | dir | handshake              | payload
//   --------+-----+------------------------+--------------------------------
//   in_     | in  | in_tvalid / in_tready  | tdata: rx_byte
//   out_    | out | out_tvalid / out_tready| tdata: tx_byte, tlast: frame_end,
//           |     |                        | tuser: checksum_ok
//   cfg_    | in  | cfg_we                 | cfg_index, cfg_data
//
// One word per cycle unless the output stalls: each word is parsed in the
// cycle it is accepted and is in the output register the next cycle.
// The output register is the only stage; a new word is taken whenever that
// register is empty or is being drained in the same cycle.
// Words outside a frame are consumed without producing a result.
// Reset (rst_n low, synchronous) returns to header hunt, clears both sums and
// loads the register defaults.
module frame_receive_patch_resend_core
  import frp_pkg::*;
#(
  parameter int FRAME_BYTES = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] rx_byte
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,   // [7:0] tx_byte
  output logic       out_tlast,   // frame_end
  output logic       out_tuser,   // checksum_ok
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam int CMP_W = (POS_W > 7) ? POS_W : 7;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  // configuration registers
  logic       patch_en_r;
  logic [6:0] patch_off_r;
  logic [7:0] patch_val_r;

  // parser state
  phase_t           phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       rsum_r, rsum_nxt;
  logic [7:0]       ssum_r, ssum_nxt;

  // output register
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_ok_r, out_ok_nxt;

  logic             accept;
  logic             emit;
  logic [POS_W-1:0] base_pos;
  logic [7:0]       base_rsum;
  logic [7:0]       base_ssum;
  logic [7:0]       fwd_byte;
  logic [POS_W-1:0] pos_inc;

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // configuration write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      patch_en_r  <= PATCH_ENABLE_RST;
      patch_off_r <= PATCH_OFFSET_RST;
      patch_val_r <= PATCH_VALUE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PATCH_ENABLE: patch_en_r  <= cfg_data[0];
        REG_PATCH_OFFSET: patch_off_r <= cfg_data[6:0];
        REG_PATCH_VALUE:  patch_val_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // frame byte path: a header restarts position and sums
  always_comb begin
    base_pos  = (phase_r == PH_HUNT) ? '0 : pos_r;
    base_rsum = (phase_r == PH_HUNT) ? '0 : rsum_r;
    base_ssum = (phase_r == PH_HUNT) ? '0 : ssum_r;
    fwd_byte  = (patch_en_r && (CMP_W'(base_pos) == CMP_W'(patch_off_r))) ?
                patch_val_r : in_tdata;
    pos_inc   = base_pos + 1'b1;
  end

  // next state and result
  always_comb begin
    phase_nxt     = phase_r;
    pos_nxt       = pos_r;
    rsum_nxt      = rsum_r;
    ssum_nxt      = ssum_r;
    emit          = 1'b0;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_ok_nxt    = out_ok_r;
    if (accept) begin
      unique case (phase_r)
        PH_HUNT: begin
          if (in_tdata == HEADER_BYTE) begin
            emit      = 1'b1;
            phase_nxt = PH_WAIT;
          end
        end
        PH_WAIT: begin
          if (in_tdata == SECOND_BYTE) begin
            emit      = 1'b1;
            phase_nxt = (pos_inc >= LAST_POS) ? PH_TRAIL : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          emit      = 1'b1;
          phase_nxt = (pos_inc >= LAST_POS) ? PH_TRAIL : PH_PAYLOAD;
        end
        PH_TRAIL: begin
          phase_nxt = PH_HUNT;
          pos_nxt   = '0;
        end
        default: ;
      endcase
      if (emit) begin
        pos_nxt      = pos_inc;
        rsum_nxt     = base_rsum + in_tdata;
        ssum_nxt     = base_ssum + fwd_byte;
        out_byte_nxt = fwd_byte;
        out_last_nxt = 1'b0;
        out_ok_nxt   = 1'b0;
      end else if (phase_r == PH_TRAIL) begin
        out_byte_nxt = ssum_r;
        out_last_nxt = 1'b1;
        out_ok_nxt   = (in_tdata == rsum_r);
      end
    end
    // output register load / drain
    if (accept && (emit || phase_r == PH_TRAIL)) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      pos_r       <= '0;
      rsum_r      <= '0;
      ssum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pos_r       <= pos_nxt;
      rsum_r      <= rsum_nxt;
      ssum_r      <= ssum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_ok_r   <= out_ok_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_ok_r;

  // checks
  a_result_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready))
    else $error("result appeared without an accepted word");

  a_ok_only_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast)
    else $error("checksum_ok set on a non-trailer word");

  a_hunt_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_HUNT) |-> (pos_r == '0))
    else $error("position not cleared while hunting");

  a_trailer_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && phase_r == PH_TRAIL) |=>
      (phase_r == PH_HUNT && out_tvalid && out_tlast))
    else $error("trailer did not close the frame");

endmodule
